### src/dcdn_pkg.sv
// Shared constants, record types and register codes for the candidate decode and NMS block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package dcdn_pkg;

    // Storage sizes.
    localparam int MAX_STORED  = 256;
    localparam int MAX_CLASSES = 16;
    localparam int MAX_KEPT    = 64;

    localparam int IDX_W      = $clog2(MAX_STORED);
    localparam int CNT_W      = $clog2(MAX_STORED + 1);
    localparam int KIDX_W     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int KCNT_W     = $clog2(MAX_KEPT + 1);
    localparam int CLS_CNT_W  = $clog2(MAX_CLASSES + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    // Field widths.
    localparam int SCORE_W = 16;
    localparam int CLS_W   = 4;
    localparam int BOX_W   = 14;
    localparam int POS_W   = 11;
    localparam int SIZE_W  = 10;
    localparam int PAD_W   = 12;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE   = 3'd4;

    // Register reset values.
    localparam logic [SCORE_W-1:0] RST_SCORE_THR   = 16'd32768;
    localparam logic [SCORE_W-1:0] RST_OVERLAP_THR = 16'd29491;
    localparam logic [PAD_W-1:0]   RST_PAD         = 12'd0;
    localparam logic [CFG_W-1:0]   RST_INV_SCALE   = 16'd4096;

    // One stored candidate: score, class and box in whole model pixels.
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [CLS_W-1:0]   cls;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
    } cand_t;

    // Request from the front to the back.
    typedef struct packed {
        logic  store;
        logic  frame_end;
        cand_t cand;
    } cand_req_t;

    // Settings the back part uses.
    typedef struct packed {
        logic [SCORE_W-1:0] overlap_thr;
        logic [PAD_W-1:0]   pad_x;
        logic [PAD_W-1:0]   pad_y;
        logic [CFG_W-1:0]   inv_scale;
    } back_cfg_t;

endpackage

### src/dcdn_front.sv
// Front part: accepts class-score items, tracks the best class, and queues candidate requests.
// Depends on dcdn_pkg.
`timescale 1ns / 1ps

module dcdn_front import dcdn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 stall,
    input  logic [BOX_W-1:0]     center_x,
    input  logic [BOX_W-1:0]     center_y,
    input  logic [BOX_W-1:0]     box_width,
    input  logic [BOX_W-1:0]     box_height,
    input  logic [SCORE_W-1:0]   class_score,
    input  logic                 last_class,
    input  logic                 last_candidate,
    input  logic [SCORE_W-1:0]   score_threshold,
    input  logic                 queue_full,
    output logic                 push,
    output cand_req_t            req
);

    logic [SCORE_W-1:0]   best_score_reg, best_score_next;
    logic [CLS_W-1:0]     best_cls_reg, best_cls_next;
    logic                 best_valid_reg, best_valid_next;
    logic [CLS_CNT_W-1:0] cls_cnt_reg, cls_cnt_next;
    logic                 accept;
    logic                 cand_end;
    logic                 qualifies;
    logic signed [16:0]   edge_x2;
    logic signed [16:0]   edge_y2;
    logic signed [16:0]   left_q;
    logic signed [16:0]   top_q;

    assign stall  = queue_full;
    assign accept = valid && !queue_full;
    assign cand_end = last_class || last_candidate;

    // Running best class; scores past the class limit are ignored.
    always_comb
    begin
        best_score_next = best_score_reg;
        best_cls_next   = best_cls_reg;
        best_valid_next = best_valid_reg;
        cls_cnt_next    = cls_cnt_reg;
        if (cls_cnt_reg < CLS_CNT_W'(MAX_CLASSES))
        begin
            if (class_score > best_score_reg)
            begin
                best_score_next = class_score;
                best_cls_next   = cls_cnt_reg[CLS_W-1:0];
                best_valid_next = 1'b1;
            end
            cls_cnt_next = cls_cnt_reg + 1'b1;
        end
    end

    assign qualifies = best_valid_next && (best_score_next > score_threshold);

    // Box corner in whole pixels, truncated toward zero.
    always_comb
    begin
        edge_x2 = $signed({2'b00, center_x, 1'b0}) - $signed({3'b000, box_width});
        edge_y2 = $signed({2'b00, center_y, 1'b0}) - $signed({3'b000, box_height});
        left_q  = edge_x2[16] ? ((edge_x2 + 17'sd31) >>> 5) : (edge_x2 >>> 5);
        top_q   = edge_y2[16] ? ((edge_y2 + 17'sd31) >>> 5) : (edge_y2 >>> 5);
    end

    always_comb
    begin
        push              = accept && cand_end && (qualifies || last_candidate);
        req.store         = qualifies;
        req.frame_end     = last_candidate;
        req.cand.score    = best_score_next;
        req.cand.cls      = best_cls_next;
        req.cand.x        = left_q[POS_W-1:0];
        req.cand.y        = top_q[POS_W-1:0];
        req.cand.w        = box_width[BOX_W-1:4];
        req.cand.h        = box_height[BOX_W-1:4];
    end

    // Tracker registers clear at each candidate end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= '0;
            best_cls_reg   <= '0;
            best_valid_reg <= 1'b0;
            cls_cnt_reg    <= '0;
        end
        else if (accept)
        begin
            if (cand_end)
            begin
                best_score_reg <= '0;
                best_cls_reg   <= '0;
                best_valid_reg <= 1'b0;
                cls_cnt_reg    <= '0;
            end
            else
            begin
                best_score_reg <= best_score_next;
                best_cls_reg   <= best_cls_next;
                best_valid_reg <= best_valid_next;
                cls_cnt_reg    <= cls_cnt_next;
            end
        end
    end

endmodule

### src/dcdn_queue.sv
// Short request queue between the front and back parts.
// Depends on dcdn_pkg.
`timescale 1ns / 1ps

module dcdn_queue import dcdn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cand_req_t push_req,
    output logic      full,
    input  logic      pop,
    output logic      nonempty,
    output cand_req_t head
);

    cand_req_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]      fill_reg;

    assign full     = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign nonempty = (fill_reg != '0);
    assign head     = slot_reg[rd_ptr_reg];

    // Payload slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

### src/dcdn_back.sv
// Back part: candidate table, stable rank sort, greedy suppression and box mapping.
// Depends on dcdn_pkg.
`timescale 1ns / 1ps

module dcdn_back import dcdn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  cand_req_t          req,
    output logic               pop,
    input  back_cfg_t          cfg,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CLS_W-1:0]   class_id,
    output logic [SCORE_W-1:0] confidence,
    output logic [13:0]        out_x,
    output logic [13:0]        out_y,
    output logic [12:0]        out_width,
    output logic [12:0]        out_height,
    output logic [14:0]        center_x_half,
    output logic [14:0]        center_y_half,
    output logic               last_box,
    output logic               none_found,
    output logic               overflowed
);

    localparam logic [4:0] S_LOAD   = 5'd0;
    localparam logic [4:0] S_RK_I   = 5'd1;
    localparam logic [4:0] S_RK_IW  = 5'd2;
    localparam logic [4:0] S_RK_J   = 5'd3;
    localparam logic [4:0] S_NM_R   = 5'd4;
    localparam logic [4:0] S_NM_RW  = 5'd5;
    localparam logic [4:0] S_NM_CW  = 5'd6;
    localparam logic [4:0] S_NM_K   = 5'd7;
    localparam logic [4:0] S_NM_P1  = 5'd8;
    localparam logic [4:0] S_NM_P2  = 5'd9;
    localparam logic [4:0] S_NM_P3  = 5'd10;
    localparam logic [4:0] S_NM_P4  = 5'd11;
    localparam logic [4:0] S_NM_DEC = 5'd12;
    localparam logic [4:0] S_OUT_R  = 5'd13;
    localparam logic [4:0] S_OUT_M  = 5'd14;
    localparam logic [4:0] S_OUT_F  = 5'd15;
    localparam logic [4:0] S_OUT_W  = 5'd16;

    // Memories.
    cand_t            cand_mem   [MAX_STORED];
    logic [IDX_W-1:0] sorted_mem [MAX_STORED];
    cand_t            kept_mem   [MAX_KEPT];

    cand_t             cand_rd_reg;
    logic [IDX_W-1:0]  sorted_rd_reg;
    cand_t             kept_rd_reg;
    logic [IDX_W-1:0]  cand_rd_addr;
    logic [IDX_W-1:0]  sorted_rd_addr;
    logic [KIDX_W-1:0] kept_rd_addr;
    logic              cand_we, sorted_we, kept_we;
    logic [IDX_W-1:0]  cand_wa, sorted_wa;
    logic [KIDX_W-1:0] kept_wa;
    cand_t             cand_wd;
    logic [IDX_W-1:0]  sorted_wd;

    // Control registers.
    logic [4:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  jd_reg, jd_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  rank_reg, rank_next;
    logic [KCNT_W-1:0] k_reg, k_next;
    logic [KCNT_W-1:0] nkept_reg, nkept_next;
    logic              keep_reg, keep_next;
    logic              out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [SCORE_W-1:0] si_reg, si_next;
    cand_t              cur_reg, cur_next;
    logic signed [12:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [19:0]        aa_reg, aa_next, ab_reg, ab_next;
    logic [19:0]        inter_reg, inter_next;
    logic [20:0]        sum_reg, sum_next;
    logic [36:0]        prod_reg, prod_next;
    logic signed [30:0] px_reg, px_next, py_reg, py_next;
    logic [25:0]        pw_reg, pw_next, ph_reg, ph_next;
    logic [CLS_W-1:0]   ecls_reg, ecls_next;
    logic [SCORE_W-1:0] escore_reg, escore_next;

    // Output registers.
    logic [CLS_W-1:0]   o_cls_reg, o_cls_next;
    logic [SCORE_W-1:0] o_conf_reg, o_conf_next;
    logic [13:0]        o_x_reg, o_x_next, o_y_reg, o_y_next;
    logic [12:0]        o_w_reg, o_w_next, o_h_reg, o_h_next;
    logic [14:0]        o_cx_reg, o_cx_next, o_cy_reg, o_cy_next;
    logic               o_last_reg, o_last_next;
    logic               o_none_reg, o_none_next;
    logic               o_ovf_reg, o_ovf_next;

    // Combinational helpers.
    logic signed [12:0] ax_lo, bx_lo, ay_lo, by_lo, ax_hi, bx_hi, ay_hi, by_hi;
    logic signed [12:0] x1, x2, y1, y2;
    logic signed [13:0] map_dx, map_dy;
    logic signed [30:0] qx, qy;
    logic signed [17:0] qx_n, qy_n;
    logic signed [13:0] ox, oy;
    logic [13:0]        ow_raw, oh_raw;
    logic [12:0]        ow, oh;
    logic signed [15:0] cxs, cys;
    logic [CNT_W-1:0]   load_count;
    logic               supp;

    // Candidate memory, one write and one registered read.
    always_ff @(posedge clk)
    begin
        if (cand_we)
        begin
            cand_mem[cand_wa] <= cand_wd;
        end
        cand_rd_reg <= cand_mem[cand_rd_addr];
    end

    // Sorted order memory.
    always_ff @(posedge clk)
    begin
        if (sorted_we)
        begin
            sorted_mem[sorted_wa] <= sorted_wd;
        end
        sorted_rd_reg <= sorted_mem[sorted_rd_addr];
    end

    // Kept box memory.
    always_ff @(posedge clk)
    begin
        if (kept_we)
        begin
            kept_mem[kept_wa] <= cur_reg;
        end
        kept_rd_reg <= kept_mem[kept_rd_addr];
    end

    // Overlap geometry of the current candidate against one kept box.
    always_comb
    begin
        ax_lo = 13'(signed'(cur_reg.x));
        ay_lo = 13'(signed'(cur_reg.y));
        bx_lo = 13'(signed'(kept_rd_reg.x));
        by_lo = 13'(signed'(kept_rd_reg.y));
        ax_hi = ax_lo + $signed({3'b000, cur_reg.w});
        ay_hi = ay_lo + $signed({3'b000, cur_reg.h});
        bx_hi = bx_lo + $signed({3'b000, kept_rd_reg.w});
        by_hi = by_lo + $signed({3'b000, kept_rd_reg.h});
        x1 = (ax_lo > bx_lo) ? ax_lo : bx_lo;
        y1 = (ay_lo > by_lo) ? ay_lo : by_lo;
        x2 = (ax_hi < bx_hi) ? ax_hi : bx_hi;
        y2 = (ay_hi < by_hi) ? ay_hi : by_hi;
    end

    assign supp = (sum_reg == '0) || ({inter_reg, 16'h0000} > prod_reg[35:0])
                  && !prod_reg[36] || (sum_reg == '0);

    // Letterbox mapping of one kept box.
    always_comb
    begin
        map_dx = $signed({{2{kept_rd_reg.x[POS_W-1]}}, kept_rd_reg.x, 1'b0})
                 - $signed({2'b00, cfg.pad_x});
        map_dy = $signed({{2{kept_rd_reg.y[POS_W-1]}}, kept_rd_reg.y, 1'b0})
                 - $signed({2'b00, cfg.pad_y});
        qx = px_reg[30] ? ((px_reg + 31'sd8191) >>> 13) : (px_reg >>> 13);
        qy = py_reg[30] ? ((py_reg + 31'sd8191) >>> 13) : (py_reg >>> 13);
        qx_n = qx[17:0];
        qy_n = qy[17:0];
        if (qx_n > 18'sd8191)
        begin
            ox = 14'sd8191;
        end
        else if (qx_n < -18'sd8192)
        begin
            ox = -14'sd8192;
        end
        else
        begin
            ox = qx_n[13:0];
        end
        if (qy_n > 18'sd8191)
        begin
            oy = 14'sd8191;
        end
        else if (qy_n < -18'sd8192)
        begin
            oy = -14'sd8192;
        end
        else
        begin
            oy = qy_n[13:0];
        end
        ow_raw = pw_reg[25:12];
        oh_raw = ph_reg[25:12];
        ow = ow_raw[13] ? 13'd8191 : ow_raw[12:0];
        oh = oh_raw[13] ? 13'd8191 : oh_raw[12:0];
        cxs = $signed({ox[13], ox, 1'b0}) + $signed({3'b000, ow});
        cys = $signed({oy[13], oy, 1'b0}) + $signed({3'b000, oh});
    end

    assign load_count = count_reg + ((req.store && (count_reg < CNT_W'(MAX_STORED)))
                                     ? CNT_W'(1) : CNT_W'(0));

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        jd_next        = jd_reg;
        pend_next      = 1'b0;
        rank_next      = rank_reg;
        k_next         = k_reg;
        nkept_next     = nkept_reg;
        keep_next      = keep_reg;
        out_valid_next = out_valid_reg;
        si_next        = si_reg;
        cur_next       = cur_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        aa_next        = aa_reg;
        ab_next        = ab_reg;
        inter_next     = inter_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pw_next        = pw_reg;
        ph_next        = ph_reg;
        ecls_next      = ecls_reg;
        escore_next    = escore_reg;
        o_cls_next     = o_cls_reg;
        o_conf_next    = o_conf_reg;
        o_x_next       = o_x_reg;
        o_y_next       = o_y_reg;
        o_w_next       = o_w_reg;
        o_h_next       = o_h_reg;
        o_cx_next      = o_cx_reg;
        o_cy_next      = o_cy_reg;
        o_last_next    = o_last_reg;
        o_none_next    = o_none_reg;
        o_ovf_next     = o_ovf_reg;
        pop            = 1'b0;
        cand_we        = 1'b0;
        cand_wa        = count_reg[IDX_W-1:0];
        cand_wd        = req.cand;
        sorted_we      = 1'b0;
        sorted_wa      = rank_reg;
        sorted_wd      = i_reg[IDX_W-1:0];
        kept_we        = 1'b0;
        kept_wa        = nkept_reg[KIDX_W-1:0];
        cand_rd_addr   = '0;
        sorted_rd_addr = '0;
        kept_rd_addr   = '0;

        case (state_reg)
            // Take requests from the queue into the table.
            S_LOAD:
            begin
                if (req_valid)
                begin
                    pop = 1'b1;
                    if (req.store)
                    begin
                        if (count_reg < CNT_W'(MAX_STORED))
                        begin
                            cand_we = 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    count_next = load_count;
                    if (req.frame_end)
                    begin
                        i_next = '0;
                        state_next = (load_count == '0) ? S_OUT_R : S_RK_I;
                    end
                end
            end
            // Rank of entry i: entries ahead of it in a stable descending order.
            S_RK_I:
            begin
                cand_rd_addr = i_reg[IDX_W-1:0];
                state_next = S_RK_IW;
            end
            S_RK_IW:
            begin
                si_next   = cand_rd_reg.score;
                j_next    = '0;
                rank_next = '0;
                state_next = S_RK_J;
            end
            S_RK_J:
            begin
                cand_rd_addr = j_reg[IDX_W-1:0];
                if (pend_reg && ((cand_rd_reg.score > si_reg) ||
                    ((cand_rd_reg.score == si_reg) && (jd_reg < i_reg[IDX_W-1:0]))))
                begin
                    rank_next = rank_reg + 1'b1;
                end
                if (j_reg < count_reg)
                begin
                    pend_next = 1'b1;
                    jd_next   = j_reg[IDX_W-1:0];
                    j_next    = j_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    sorted_we = 1'b1;
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 == count_reg)
                    begin
                        i_next = '0;
                        nkept_next = '0;
                        state_next = S_NM_R;
                    end
                    else
                    begin
                        state_next = S_RK_I;
                    end
                end
            end
            // Suppression, in sorted order against each kept box until one suppresses the candidate.
            S_NM_R:
            begin
                sorted_rd_addr = i_reg[IDX_W-1:0];
                state_next = S_NM_RW;
            end
            S_NM_RW:
            begin
                cand_rd_addr = sorted_rd_reg;
                state_next = S_NM_CW;
            end
            S_NM_CW:
            begin
                cur_next  = cand_rd_reg;
                k_next    = '0;
                keep_next = 1'b1;
                state_next = (nkept_reg == '0) ? S_NM_DEC : S_NM_K;
            end
            S_NM_K:
            begin
                kept_rd_addr = k_reg[KIDX_W-1:0];
                state_next = S_NM_P1;
            end
            S_NM_P1:
            begin
                dx_next = x2 - x1;
                dy_next = y2 - y1;
                aa_next = cur_reg.w * cur_reg.h;
                ab_next = kept_rd_reg.w * kept_rd_reg.h;
                state_next = S_NM_P2;
            end
            S_NM_P2:
            begin
                inter_next = ((dx_reg > 13'sd0) && (dy_reg > 13'sd0))
                             ? (dx_reg[SIZE_W-1:0] * dy_reg[SIZE_W-1:0]) : 20'd0;
                sum_next = {1'b0, aa_reg} + {1'b0, ab_reg};
                state_next = S_NM_P3;
            end
            S_NM_P3:
            begin
                prod_next = cfg.overlap_thr * (sum_reg - {1'b0, inter_reg});
                state_next = S_NM_P4;
            end
            S_NM_P4:
            begin
                if (supp)
                begin
                    keep_next = 1'b0;
                    state_next = S_NM_DEC;
                end
                else if (k_reg + 1'b1 == nkept_reg)
                begin
                    state_next = S_NM_DEC;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_NM_K;
                end
            end
            S_NM_DEC:
            begin
                if (keep_reg)
                begin
                    if (nkept_reg < KCNT_W'(MAX_KEPT))
                    begin
                        kept_we = 1'b1;
                        nkept_next = nkept_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 == count_reg)
                begin
                    k_next = '0;
                    state_next = S_OUT_R;
                end
                else
                begin
                    state_next = S_NM_R;
                end
            end
            // Emit kept boxes, or a single empty-frame result.
            S_OUT_R:
            begin
                kept_rd_addr = k_reg[KIDX_W-1:0];
                if (nkept_reg == '0)
                begin
                    o_cls_next  = '0;
                    o_conf_next = '0;
                    o_x_next    = '0;
                    o_y_next    = '0;
                    o_w_next    = '0;
                    o_h_next    = '0;
                    o_cx_next   = '0;
                    o_cy_next   = '0;
                    o_last_next = 1'b1;
                    o_none_next = 1'b1;
                    o_ovf_next  = ovf_reg;
                    out_valid_next = 1'b1;
                    state_next = S_OUT_W;
                end
                else
                begin
                    state_next = S_OUT_M;
                end
            end
            S_OUT_M:
            begin
                px_next = map_dx * $signed({1'b0, cfg.inv_scale});
                py_next = map_dy * $signed({1'b0, cfg.inv_scale});
                pw_next = kept_rd_reg.w * cfg.inv_scale;
                ph_next = kept_rd_reg.h * cfg.inv_scale;
                ecls_next   = kept_rd_reg.cls;
                escore_next = kept_rd_reg.score;
                state_next = S_OUT_F;
            end
            S_OUT_F:
            begin
                o_cls_next  = ecls_reg;
                o_conf_next = escore_reg;
                o_x_next    = ox;
                o_y_next    = oy;
                o_w_next    = ow;
                o_h_next    = oh;
                o_cx_next   = (cxs > 16'sd16383) ? 15'd16383 : cxs[14:0];
                o_cy_next   = (cys > 16'sd16383) ? 15'd16383 : cys[14:0];
                o_last_next = (k_reg + 1'b1 == nkept_reg);
                o_none_next = 1'b0;
                o_ovf_next  = ovf_reg;
                out_valid_next = 1'b1;
                state_next = S_OUT_W;
            end
            S_OUT_W:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (o_last_reg)
                    begin
                        count_next = '0;
                        nkept_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        state_next = S_OUT_R;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            pend_reg      <= 1'b0;
            rank_reg      <= '0;
            k_reg         <= '0;
            nkept_reg     <= '0;
            keep_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            pend_reg      <= pend_next;
            rank_reg      <= rank_next;
            k_reg         <= k_next;
            nkept_reg     <= nkept_next;
            keep_reg      <= keep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output payload.
    always_ff @(posedge clk)
    begin
        jd_reg     <= jd_next;
        si_reg     <= si_next;
        cur_reg    <= cur_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        aa_reg     <= aa_next;
        ab_reg     <= ab_next;
        inter_reg  <= inter_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        pw_reg     <= pw_next;
        ph_reg     <= ph_next;
        ecls_reg   <= ecls_next;
        escore_reg <= escore_next;
        o_cls_reg  <= o_cls_next;
        o_conf_reg <= o_conf_next;
        o_x_reg    <= o_x_next;
        o_y_reg    <= o_y_next;
        o_w_reg    <= o_w_next;
        o_h_reg    <= o_h_next;
        o_cx_reg   <= o_cx_next;
        o_cy_reg   <= o_cy_next;
        o_last_reg <= o_last_next;
        o_none_reg <= o_none_next;
        o_ovf_reg  <= o_ovf_next;
    end

    assign out_valid     = out_valid_reg;
    assign class_id      = o_cls_reg;
    assign confidence    = o_conf_reg;
    assign out_x         = o_x_reg;
    assign out_y         = o_y_reg;
    assign out_width     = o_w_reg;
    assign out_height    = o_h_reg;
    assign center_x_half = o_cx_reg;
    assign center_y_half = o_cy_reg;
    assign last_box      = o_last_reg;
    assign none_found    = o_none_reg;
    assign overflowed    = o_ovf_reg;

endmodule

### src/detector_candidate_decode_nms.sv
// Top level of the detector candidate decode and NMS block: configuration registers and the
// front, queue and back parts. Depends on dcdn_pkg, dcdn_front, dcdn_queue and dcdn_back.
//
// Candidates stream in one class score per request, one request per cycle while a frame is
// being loaded and stall is low; the front tracks the best class and a four-entry queue
// feeds the table writer. After the request with last_candidate the back sorts the stored
// candidates by a rank count over the table, then runs greedy suppression over each
// candidate and kept-box pair, then emits each kept box, held by output stall. New
// candidates are held off by stall while the back finishes a frame once the queue has
// filled. Configuration writes take effect at once and are meant for idle time only.
`timescale 1ns / 1ps

module detector_candidate_decode_nms import dcdn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 cand_valid,
    output logic                 cand_stall,
    input  logic [BOX_W-1:0]     center_x,
    input  logic [BOX_W-1:0]     center_y,
    input  logic [BOX_W-1:0]     box_width,
    input  logic [BOX_W-1:0]     box_height,
    input  logic [SCORE_W-1:0]   class_score,
    input  logic                 last_class,
    input  logic                 last_candidate,
    output logic                 box_valid,
    input  logic                 box_stall,
    output logic [CLS_W-1:0]     class_id,
    output logic [SCORE_W-1:0]   confidence,
    output logic [13:0]          out_x,
    output logic [13:0]          out_y,
    output logic [12:0]          out_width,
    output logic [12:0]          out_height,
    output logic [14:0]          center_x_half,
    output logic [14:0]          center_y_half,
    output logic                 last_box,
    output logic                 none_found,
    output logic                 overflowed
);

    logic [SCORE_W-1:0] score_thr_reg;
    back_cfg_t          back_cfg_reg;
    logic               q_push, q_full, q_pop, q_nonempty;
    cand_req_t          q_in, q_head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_thr_reg            <= RST_SCORE_THR;
            back_cfg_reg.overlap_thr <= RST_OVERLAP_THR;
            back_cfg_reg.pad_x       <= RST_PAD;
            back_cfg_reg.pad_y       <= RST_PAD;
            back_cfg_reg.inv_scale   <= RST_INV_SCALE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCORE_THR:   score_thr_reg            <= cfg_data;
                CFG_OVERLAP_THR: back_cfg_reg.overlap_thr <= cfg_data;
                CFG_PAD_X:       back_cfg_reg.pad_x       <= cfg_data[PAD_W-1:0];
                CFG_PAD_Y:       back_cfg_reg.pad_y       <= cfg_data[PAD_W-1:0];
                CFG_INV_SCALE:   back_cfg_reg.inv_scale   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front: best class tracking and candidate requests.
    dcdn_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .valid           (cand_valid),
        .stall           (cand_stall),
        .center_x        (center_x),
        .center_y        (center_y),
        .box_width       (box_width),
        .box_height      (box_height),
        .class_score     (class_score),
        .last_class      (last_class),
        .last_candidate  (last_candidate),
        .score_threshold (score_thr_reg),
        .queue_full      (q_full),
        .push            (q_push),
        .req             (q_in)
    );

    // Queue between the two parts.
    dcdn_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_req (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    // Back: table, sort, suppression and output.
    dcdn_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (q_nonempty),
        .req           (q_head),
        .pop           (q_pop),
        .cfg           (back_cfg_reg),
        .out_valid     (box_valid),
        .out_stall     (box_stall),
        .class_id      (class_id),
        .confidence    (confidence),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_width     (out_width),
        .out_height    (out_height),
        .center_x_half (center_x_half),
        .center_y_half (center_y_half),
        .last_box      (last_box),
        .none_found    (none_found),
        .overflowed    (overflowed)
    );

endmodule

### src/dcdn_checker.sv
// Port-level checks for the detector candidate decode and NMS block, bound to its top level.
// Depends on dcdn_pkg.
`timescale 1ns / 1ps

module dcdn_checker import dcdn_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               box_valid,
    input logic               box_stall,
    input logic [CLS_W-1:0]   class_id,
    input logic [SCORE_W-1:0] confidence,
    input logic [13:0]        out_x,
    input logic [12:0]        out_width,
    input logic [14:0]        center_x_half,
    input logic               last_box,
    input logic               none_found
);

    logic signed [15:0] cx_sum;
    logic [14:0]        cx_expect;

    // Expected center from the edge and width shown.
    assign cx_sum    = $signed({out_x[13], out_x, 1'b0}) + $signed({3'b000, out_width});
    assign cx_expect = (cx_sum > 16'sd16383) ? 15'd16383 : cx_sum[14:0];

    // A stalled result stays valid and keeps its confidence and last_box.
    assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && box_stall |=> box_valid && $stable(confidence) && $stable(last_box))
        else $error("result changed while stalled");

    // The empty-frame result closes the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && none_found |-> last_box)
        else $error("empty-frame result without last_box");

    // The empty-frame result carries no box.
    assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && none_found |-> class_id == '0 && confidence == '0 && out_x == '0)
        else $error("empty-frame result has box fields");

    // The x center agrees with the x edge and width.
    assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !none_found |-> center_x_half == cx_expect)
        else $error("center does not match edge and width");

endmodule

bind detector_candidate_decode_nms dcdn_checker u_dcdn_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .box_valid     (box_valid),
    .box_stall     (box_stall),
    .class_id      (class_id),
    .confidence    (confidence),
    .out_x         (out_x),
    .out_width     (out_width),
    .center_x_half (center_x_half),
    .last_box      (last_box),
    .none_found    (none_found)
);

### tb/tb.sv
// Self-checking testbench for detector_candidate_decode_nms: streams candidate requests,
// predicts every emitted box in a behavioral model and checks results in order.
// Depends on dcdn_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import dcdn_pkg::*;

    // One emitted box as the block presents it.
    typedef struct {
        logic [3:0]  cls;
        logic [15:0] conf;
        logic [13:0] x;
        logic [13:0] y;
        logic [12:0] w;
        logic [12:0] h;
        logic [14:0] cxh;
        logic [14:0] cyh;
        logic        lastb;
        logic        none;
        logic        ovf;
    } box_result_t;

    localparam int CYCLE_LIMIT = 1500000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 cand_valid;
    logic                 cand_stall;
    logic [BOX_W-1:0]     center_x;
    logic [BOX_W-1:0]     center_y;
    logic [BOX_W-1:0]     box_width;
    logic [BOX_W-1:0]     box_height;
    logic [SCORE_W-1:0]   class_score;
    logic                 last_class;
    logic                 last_candidate;
    logic                 box_valid;
    logic                 box_stall;
    logic [CLS_W-1:0]     class_id;
    logic [SCORE_W-1:0]   confidence;
    logic [13:0]          out_x;
    logic [13:0]          out_y;
    logic [12:0]          out_width;
    logic [12:0]          out_height;
    logic [14:0]          center_x_half;
    logic [14:0]          center_y_half;
    logic                 last_box;
    logic                 none_found;
    logic                 overflowed;

    detector_candidate_decode_nms u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cand_valid(cand_valid), .cand_stall(cand_stall),
        .center_x(center_x), .center_y(center_y),
        .box_width(box_width), .box_height(box_height),
        .class_score(class_score), .last_class(last_class),
        .last_candidate(last_candidate),
        .box_valid(box_valid), .box_stall(box_stall),
        .class_id(class_id), .confidence(confidence),
        .out_x(out_x), .out_y(out_y), .out_width(out_width), .out_height(out_height),
        .center_x_half(center_x_half), .center_y_half(center_y_half),
        .last_box(last_box), .none_found(none_found), .overflowed(overflowed)
    );

    // Model copy of the registers.
    int unsigned thr_score, thr_overlap, pad_x, pad_y, inv_scale;

    // Model copy of the frame state.
    int unsigned best_score;
    int          top_class;
    int unsigned class_count;
    int unsigned table_count;
    bit          table_overflow;
    int unsigned tab_score [MAX_STORED];
    int unsigned tab_class [MAX_STORED];
    int          tab_x [MAX_STORED];
    int          tab_y [MAX_STORED];
    int          tab_w [MAX_STORED];
    int          tab_h [MAX_STORED];

    box_result_t pending_boxes[$];
    int          error_count;
    int          requests_sent;
    int          boxes_checked;
    int          frames_sent;
    int          cycle_count;
    bit          idle_on;
    int          hold_off;
    int          out_wait;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d boxes still pending",
                         cycle_count, pending_boxes.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // True when box a overlaps kept box b beyond the overlap threshold.
    function automatic bit overlaps_too_much(int a, int b);
        longint area_a, area_b, x1, y1, x2, y2, inter, uni;
        area_a = longint'(tab_w[a]) * tab_h[a];
        area_b = longint'(tab_w[b]) * tab_h[b];
        inter = 0;
        if (area_a + area_b <= 0)
            return 1'b1;
        x1 = (tab_x[a] > tab_x[b]) ? tab_x[a] : tab_x[b];
        y1 = (tab_y[a] > tab_y[b]) ? tab_y[a] : tab_y[b];
        x2 = ((tab_x[a] + tab_w[a]) < (tab_x[b] + tab_w[b])) ?
             (tab_x[a] + tab_w[a]) : (tab_x[b] + tab_w[b]);
        y2 = ((tab_y[a] + tab_h[a]) < (tab_y[b] + tab_h[b])) ?
             (tab_y[a] + tab_h[a]) : (tab_y[b] + tab_h[b]);
        if (x2 > x1 && y2 > y1)
            inter = (x2 - x1) * (y2 - y1);
        uni = area_a + area_b - inter;
        return (inter * 65536) > (longint'(thr_overlap) * uni);
    endfunction

    // Sort, suppress and map one finished frame into expected boxes.
    function automatic void finish_frame();
        int          order[$];
        int          kept[$];
        int          pos;
        bit          keep;
        longint      ox, oy, ow, oh, cxv, cyv;
        longint      inv, px, py;
        box_result_t r;
        inv = longint'(inv_scale);
        px = longint'(pad_x);
        py = longint'(pad_y);
        // Stable insertion by descending score.
        for (int i = 0; i < table_count; i++)
        begin
            pos = order.size();
            while (pos > 0 && tab_score[order[pos-1]] < tab_score[i])
                pos--;
            order.insert(pos, i);
        end
        foreach (order[i])
        begin
            keep = 1'b1;
            foreach (kept[j])
                if (keep && overlaps_too_much(order[i], kept[j]))
                    keep = 1'b0;
            if (keep)
            begin
                if (kept.size() < MAX_KEPT)
                    kept.insert(kept.size(), order[i]);
                else
                    table_overflow = 1'b1;
            end
        end
        if (kept.size() == 0)
        begin
            r = '{default: '0};
            r.lastb = 1'b1;
            r.none = 1'b1;
            r.ovf = table_overflow;
            pending_boxes.insert(pending_boxes.size(), r);
        end
        foreach (kept[i])
        begin
            ox = clamp((2 * longint'(tab_x[kept[i]]) - px) * inv / 8192, -8192, 8191);
            oy = clamp((2 * longint'(tab_y[kept[i]]) - py) * inv / 8192, -8192, 8191);
            ow = clamp(longint'(tab_w[kept[i]]) * inv / 4096, 0, 8191);
            oh = clamp(longint'(tab_h[kept[i]]) * inv / 4096, 0, 8191);
            cxv = clamp(2 * ox + ow, -16384, 16383);
            cyv = clamp(2 * oy + oh, -16384, 16383);
            r.cls = tab_class[kept[i]][3:0];
            r.conf = tab_score[kept[i]][15:0];
            r.x = ox[13:0];
            r.y = oy[13:0];
            r.w = ow[12:0];
            r.h = oh[12:0];
            r.cxh = cxv[14:0];
            r.cyh = cyv[14:0];
            r.lastb = (i == kept.size() - 1);
            r.none = 1'b0;
            r.ovf = table_overflow;
            pending_boxes.insert(pending_boxes.size(), r);
        end
        best_score = 0;
        top_class = -1;
        class_count = 0;
        table_count = 0;
        table_overflow = 1'b0;
    endfunction

    // Track the best class of the candidate and store it when it closes.
    function automatic void predict_request(int cx, int cy, int bw, int bh, int unsigned score,
                                            bit lc, bit lcand);
        if (class_count < MAX_CLASSES)
        begin
            if (score > best_score)
            begin
                best_score = score;
                top_class = class_count;
            end
            class_count++;
        end
        if (lc || lcand)
        begin
            if (top_class >= 0 && best_score > thr_score)
            begin
                if (table_count < MAX_STORED)
                begin
                    tab_x[table_count] = (2 * cx - bw) / 32;
                    tab_y[table_count] = (2 * cy - bh) / 32;
                    tab_w[table_count] = bw >> 4;
                    tab_h[table_count] = bh >> 4;
                    tab_score[table_count] = best_score;
                    tab_class[table_count] = top_class;
                    table_count++;
                end
                else
                    table_overflow = 1'b1;
            end
            best_score = 0;
            top_class = -1;
            class_count = 0;
        end
        if (lcand)
            finish_frame();
    endfunction

    // Send one request and update the model once it is accepted.
    task automatic send_request(int cx, int cy, int bw, int bh, int score, bit lc, bit lcand);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            cand_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        center_x = BOX_W'(cx);
        center_y = BOX_W'(cy);
        box_width = BOX_W'(bw);
        box_height = BOX_W'(bh);
        class_score = SCORE_W'(score);
        last_class = lc;
        last_candidate = lcand;
        cand_valid = 1'b1;
        do @(posedge clk); while (cand_stall);
        predict_request(cx, cy, bw, bh, score, lc, lcand);
        requests_sent++;
        if (lcand)
            frames_sent++;
    endtask

    // Stop sending and wait until every expected box has come out.
    task automatic wait_drained();
        @(negedge clk);
        cand_valid = 1'b0;
        wait (pending_boxes.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_W'(value);
        case (idx)
            CFG_SCORE_THR:   thr_score = value & 16'hFFFF;
            CFG_OVERLAP_THR: thr_overlap = value & 16'hFFFF;
            CFG_PAD_X:       pad_x = value & 12'hFFF;
            CFG_PAD_Y:       pad_y = value & 12'hFFF;
            CFG_INV_SCALE:   inv_scale = value & 16'hFFFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all_regs(int unsigned s, int unsigned o, int unsigned px,
                                  int unsigned py, int unsigned inv);
        write_reg(CFG_SCORE_THR, s);
        write_reg(CFG_OVERLAP_THR, o);
        write_reg(CFG_PAD_X, px);
        write_reg(CFG_PAD_Y, py);
        write_reg(CFG_INV_SCALE, inv);
    endtask

    // A well-formed frame of random candidates; clustered boxes overlap often.
    task automatic send_random_frame(int ncand, int maxcls, bit clustered);
        int ncls, cx, cy, bw, bh;
        for (int c = 0; c < ncand; c++)
        begin
            ncls = $urandom_range(1, maxcls);
            if (clustered)
            begin
                cx = 4000 + $urandom_range(0, 600);
                cy = 4000 + $urandom_range(0, 600);
                bw = $urandom_range(200, 1600);
                bh = $urandom_range(200, 1600);
            end
            else
            begin
                cx = $urandom_range(0, 16383);
                cy = $urandom_range(0, 16383);
                bw = $urandom_range(0, 16383);
                bh = $urandom_range(0, 16383);
            end
            for (int k = 0; k < ncls; k++)
                send_request(cx, cy, bw, bh, $urandom_range(0, 65535), k == ncls - 1,
                             (c == ncand - 1) && (k == ncls - 1));
        end
    endtask

    // Broken sequences: random flags, closed by a final request.
    task automatic send_noise_frame(int n);
        for (int i = 0; i < n; i++)
            send_request($urandom_range(0, 16383), $urandom_range(0, 16383),
                         $urandom_range(0, 16383), $urandom_range(0, 16383),
                         $urandom_range(0, 65535), $urandom_range(0, 3) == 0, i == n - 1);
    endtask

    // Output stall: a long hold-off when asked, otherwise a random wait per box.
    initial
    begin
        box_stall = 1'b0;
        hold_off = 0;
        out_wait = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                box_stall = 1'b1;
                hold_off--;
            end
            else if (out_wait > 0)
            begin
                box_stall = 1'b1;
                out_wait--;
            end
            else
                box_stall = 1'b0;
        end
    end

    function automatic void check_field(string name, logic [15:0] exp, logic [15:0] act);
        if (exp !== act)
        begin
            $display("%0t: box %0d field %s expected %0h got %0h",
                     $time, boxes_checked, name, exp, act);
            error_count++;
        end
    endfunction

    // Compare every accepted box with the oldest expectation.
    always @(posedge clk)
    begin
        box_result_t e;
        if (rst_n && box_valid && !box_stall)
        begin
            if (pending_boxes.size() == 0)
            begin
                $display("%0t: unexpected box, expected none, got class %0d score %0h",
                         $time, class_id, confidence);
                error_count++;
            end
            else
            begin
                e = pending_boxes.pop_front();
                check_field("class_id", e.cls, class_id);
                check_field("confidence", e.conf, confidence);
                check_field("out_x", e.x, out_x);
                check_field("out_y", e.y, out_y);
                check_field("out_width", e.w, out_width);
                check_field("out_height", e.h, out_height);
                check_field("center_x_half", e.cxh, center_x_half);
                check_field("center_y_half", e.cyh, center_y_half);
                check_field("last_box", e.lastb, last_box);
                check_field("none_found", e.none, none_found);
                check_field("overflowed", e.ovf, overflowed);
            end
            boxes_checked++;
            out_wait = idle_on ? $urandom_range(0, 9) : 0;
        end
    end

    // Extremes, class ties, extra classes, empty and zero-union frames.
    task automatic test_directed();
        send_request(100, 100, 320, 320, 100, 1'b0, 1'b0);
        send_request(100, 100, 320, 320, 65535, 1'b0, 1'b0);
        send_request(16383, 16383, 16383, 16383, 65535, 1'b1, 1'b0);
        send_request(0, 0, 16383, 16383, 40000, 1'b1, 1'b1);
        // More classes than supported, closed by the frame end alone.
        for (int k = 0; k < 17; k++)
            send_request(8000, 6000, 900, 700, (k == 15) ? 60000 : ((k == 16) ? 65535 : k),
                         1'b0, k == 16);
        send_request(500, 500, 100, 100, 0, 1'b1, 1'b1);
        send_request(300, 300, 0, 0, 50000, 1'b1, 1'b0);
        send_request(300, 300, 0, 0, 50000, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Register extremes and random settings.
    task automatic test_config_sweep();
        write_all_regs(0, 0, 0, 0, 1);
        repeat (3) send_random_frame($urandom_range(1, 5), 3, 1'b1);
        wait_drained();
        write_all_regs(65535, 65535, 4095, 4095, 65535);
        repeat (2) send_random_frame($urandom_range(1, 5), 3, 1'b0);
        wait_drained();
        write_all_regs(0, 65535, 4095, 0, 0);
        repeat (3) send_random_frame($urandom_range(1, 5), 3, 1'b0);
        wait_drained();
        write_all_regs(1, 0, 0, 4095, 65535);
        repeat (3) send_random_frame($urandom_range(1, 5), 2, 1'b1);
        wait_drained();
    endtask

    // Random frames with occasional broken sequences and register changes.
    task automatic test_random_frames();
        int target;
        target = requests_sent + 60;
        while (requests_sent < target)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                send_noise_frame($urandom_range(1, 10));
            else
                send_random_frame($urandom_range(1, 8), $urandom_range(1, 4),
                                  $urandom_range(0, 2) != 0);
            if ($urandom_range(0, 4) == 0)
            begin
                wait_drained();
                write_all_regs($urandom_range(0, 50000), $urandom_range(0, 65535),
                               $urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(1, 16384));
            end
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    // Hold the output off while frames keep arriving, so the input stalls.
    task automatic test_backpressure();
        write_all_regs(16384, 29491, 64, 32, 4096);
        idle_on = 1'b0;
        hold_off = 3000;
        repeat (2) send_random_frame(8, 2, 1'b1);
        wait_drained();
        idle_on = 1'b1;
    endtask

    // More qualifying candidates than the table holds.
    task automatic test_table_full();
        write_all_regs(0, 29491, 0, 0, 4096);
        idle_on = 1'b0;
        for (int i = 0; i < 258; i++)
            send_request($urandom_range(0, 16383), $urandom_range(0, 16383), 0, 0,
                         $urandom_range(1, 65535), 1'b1, i == 257);
        wait_drained();
        idle_on = 1'b1;
    endtask

    // More disjoint survivors than the kept list holds.
    task automatic test_kept_full();
        write_all_regs(0, 65535, 10, 20, 8192);
        for (int i = 0; i < 66; i++)
            send_request(i * 64 + 8, 8, 16, 16, 1000 + i, 1'b1, i == 65);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SCORE_THR;
        cfg_data = '0;
        cand_valid = 1'b0;
        center_x = '0;
        center_y = '0;
        box_width = '0;
        box_height = '0;
        class_score = '0;
        last_class = 1'b0;
        last_candidate = 1'b0;
        error_count = 0;
        requests_sent = 0;
        boxes_checked = 0;
        frames_sent = 0;
        idle_on = 1'b1;
        thr_score = RST_SCORE_THR;
        thr_overlap = RST_OVERLAP_THR;
        pad_x = RST_PAD;
        pad_y = RST_PAD;
        inv_scale = RST_INV_SCALE;
        best_score = 0;
        top_class = -1;
        class_count = 0;
        table_count = 0;
        table_overflow = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_table_full();
        test_kept_full();
        test_random_frames();

        $display("Covered %0d requests in %0d frames, %0d boxes checked, %0d mismatches.",
                 requests_sent, frames_sent, boxes_checked, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
